// ===== sv/arc_rp_pkg.sv =====
// ----------------------------------------------------------------------------
// arc_rp_pkg
// shared constants, codes and helpers of the byte-weighted arc policy block
// ----------------------------------------------------------------------------
package arc_rp_pkg;

    // parameter defaults
    localparam int ENTRIES_DEF   = 256;
    localparam int KEY_BITS_DEF  = 32;
    localparam int FRAC_BITS_DEF = 8;

    // fixed field widths
    localparam int SIZE_W = 24;
    localparam int CHG_W  = 25;
    localparam int LB_W   = 33;
    localparam int CNT_W  = 9;
    localparam int OC_W   = 3;
    localparam int LID_W  = 3;

    localparam logic [31:0] CAP_RESET = 32'd65536;

    // configuration register indexes
    localparam logic REG_CAPACITY = 1'b0;
    localparam logic REG_METADATA = 1'b1;

    // outcome codes
    localparam logic [OC_W-1:0] OC_MISS      = 3'd0;
    localparam logic [OC_W-1:0] OC_T1_HIT    = 3'd1;
    localparam logic [OC_W-1:0] OC_T2_HIT    = 3'd2;
    localparam logic [OC_W-1:0] OC_B1_GHOST  = 3'd3;
    localparam logic [OC_W-1:0] OC_B2_GHOST  = 3'd4;
    localparam logic [OC_W-1:0] OC_TOO_LARGE = 3'd5;
    localparam logic [OC_W-1:0] OC_FULL      = 3'd6;

    // list ids
    localparam logic [LID_W-1:0] ID_T1 = 3'd1;
    localparam logic [LID_W-1:0] ID_T2 = 3'd2;
    localparam logic [LID_W-1:0] ID_B1 = 3'd3;
    localparam logic [LID_W-1:0] ID_B2 = 3'd4;

    // list id to head/tail slot
    function automatic logic [1:0] lix(input logic [LID_W-1:0] id);
        logic [LID_W-1:0] t;
        t = id - 3'd1;
        return t[1:0];
    endfunction

    function automatic logic [LB_W-1:0] sub_sat(input logic [LB_W-1:0] a,
                                               input logic [LB_W-1:0] b);
        return (a >= b) ? (a - b) : '0;
    endfunction

endpackage

// ===== sv/arc_rp_div.sv =====
// ----------------------------------------------------------------------------
// arc_rp_div
// restoring divider, one quotient bit per cycle, for the target step ratio
// ----------------------------------------------------------------------------
module arc_rp_div #(
    parameter int FRAC_BITS = arc_rp_pkg::FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic [arc_rp_pkg::LB_W+FRAC_BITS-1:0] i_num,
    input  logic [arc_rp_pkg::LB_W-1:0]           i_den,
    output logic                                  o_done,
    output logic [arc_rp_pkg::LB_W+FRAC_BITS-1:0] o_quot
);
    localparam int NUM_W = arc_rp_pkg::LB_W + FRAC_BITS;
    localparam int CW    = $clog2(NUM_W + 1);
    localparam int LB_W  = arc_rp_pkg::LB_W;

    logic             r_busy;
    logic [CW-1:0]    r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [NUM_W-1:0] r_q;
    logic [LB_W-1:0]  r_rem;
    logic [LB_W-1:0]  r_den;
    logic             r_done;
    logic [LB_W:0]    rem_sh;
    logic             ge;

    assign rem_sh = {r_rem, r_num[NUM_W-1]};
    assign ge     = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            r_num <= r_num << 1;
            r_q   <= {r_q[NUM_W-2:0], ge};
            r_rem <= ge ? LB_W'(rem_sh - {1'b0, r_den}) : rem_sh[LB_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== sv/arc_replacement_policy_top.sv =====
// ----------------------------------------------------------------------------
// arc_replacement_policy_top
// byte-weighted adaptive replacement policy: entry table in block memories,
// linked recency/frequency/ghost lists, sequencer walks them per request
// ----------------------------------------------------------------------------
//  channel   dir  handshake                 contents
//  s         in   i_s_tvalid / o_s_tready   object_key, object_size
//  m         out  o_m_tvalid / i_m_tready   outcome, demoted, dropped, resident
//  cfg       in   i_cfg_we                  capacity_bytes, metadata_bytes
//
//  one request at a time; lookup walks the table entry by entry, reading each
//  entry (S_LRD) and comparing its key (S_LCMP); ghost hits add a division,
//  each demotion passes S_DEMCHK, S_DEM, S_PUSH and S_PRUNE plus S_DROP and
//  S_PRUNE per pruned ghost, and the free-entry scan walks up to ENTRIES entries;
//  synchronous active-low reset empties all lists at once via per-entry valid
//  bits; no clearing pass
//  the next request is taken while a result waits on m; the sequencer stalls
//  only at its final state when the output register is still occupied
// ----------------------------------------------------------------------------
module arc_replacement_policy_top #(
    parameter int ENTRIES   = arc_rp_pkg::ENTRIES_DEF,
    parameter int KEY_BITS  = arc_rp_pkg::KEY_BITS_DEF,
    parameter int FRAC_BITS = arc_rp_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [55:0] i_s_tdata,   // object_key[31:0], object_size[55:32]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,   // outcome[2:0], demoted[11:3], dropped[20:12],
                                     // resident[52:21], zero pad
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [31:0] i_cfg_wdata
);
    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int SIZE_W = arc_rp_pkg::SIZE_W;
    localparam int CHG_W  = arc_rp_pkg::CHG_W;
    localparam int LB_W   = arc_rp_pkg::LB_W;
    localparam int CNT_W  = arc_rp_pkg::CNT_W;
    localparam int OC_W   = arc_rp_pkg::OC_W;
    localparam int LID_W  = arc_rp_pkg::LID_W;
    localparam int KS_W   = KEY_BITS + SIZE_W;
    localparam int NUM_W  = LB_W + FRAC_BITS;
    localparam int P_W    = 32 + FRAC_BITS;
    localparam int SUM_W  = NUM_W + 1;

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LRD    = 4'd1;
    localparam logic [3:0] S_LCMP   = 4'd2;
    localparam logic [3:0] S_HIT    = 4'd3;
    localparam logic [3:0] S_PUSH   = 4'd4;
    localparam logic [3:0] S_DIV    = 4'd5;
    localparam logic [3:0] S_PADJ   = 4'd6;
    localparam logic [3:0] S_INSCHK = 4'd7;
    localparam logic [3:0] S_DEMCHK = 4'd8;
    localparam logic [3:0] S_DEM    = 4'd9;
    localparam logic [3:0] S_PRUNE  = 4'd10;
    localparam logic [3:0] S_DROP   = 4'd11;
    localparam logic [3:0] S_FREE   = 4'd12;
    localparam logic [3:0] S_INS    = 4'd13;
    localparam logic [3:0] S_DONE   = 4'd14;

    // entry memories
    logic [KS_W-1:0]  mem_ks   [ENTRIES];
    logic [LID_W-1:0] mem_list [ENTRIES];
    logic [IDX_W-1:0] mem_prev [ENTRIES];
    logic [IDX_W-1:0] mem_next [ENTRIES];
    logic [KS_W-1:0]  rd_ks;
    logic [LID_W-1:0] rd_list;
    logic [IDX_W-1:0] rd_prev;
    logic [IDX_W-1:0] rd_next;
    logic [IDX_W-1:0] rd_addr;

    logic             ks_we, ls_we, pv_we, nx_we;
    logic [IDX_W-1:0] ks_addr, ls_addr, pv_addr, nx_addr;
    logic [KS_W-1:0]  ks_d;
    logic [LID_W-1:0] ls_d;
    logic [IDX_W-1:0] pv_d, nx_d;

    // registers
    logic [3:0]        r_state, n_state;
    logic [ENTRIES-1:0] r_valid;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [SIZE_W-1:0] r_size, n_size;
    logic [CHG_W-1:0]  r_charge, n_charge;
    logic [IDX_W-1:0]  r_cur_idx, n_cur_idx;
    logic [LID_W-1:0]  r_cur_list, n_cur_list;
    logic [IDX_W-1:0]  r_cur_prev, n_cur_prev;
    logic [IDX_W-1:0]  r_cur_next, n_cur_next;
    logic [SIZE_W-1:0] r_cur_size, n_cur_size;
    logic [LID_W-1:0]  r_src, n_src;
    logic [LID_W-1:0]  r_dst, n_dst;
    logic [LB_W-1:0]   r_c, n_c;
    logic [3:0]        r_push_ret, n_push_ret;
    logic              r_in_b2, n_in_b2;
    logic              r_ghost, n_ghost;
    logic              r_reclaim, n_reclaim;
    logic [OC_W-1:0]   r_outcome, n_outcome;
    logic [CNT_W-1:0]  r_dem, n_dem;
    logic [CNT_W-1:0]  r_drop, n_drop;
    logic [NUM_W-1:0]  r_delta, n_delta;
    logic [IDX_W-1:0]  r_head [4], n_head [4];
    logic [IDX_W-1:0]  r_tail [4], n_tail [4];
    logic [3:0]        r_ne, n_ne;
    logic [LB_W-1:0]   r_lb [4], n_lb [4];
    logic [P_W-1:0]    r_p, n_p;
    logic [LB_W-1:0]   r_res, n_res;
    logic [31:0]       r_cap;
    logic [7:0]        r_meta;
    logic              r_out_vld;
    logic [55:0]       r_out_data;

    // unlink / push requests
    logic              do_unl, do_push;
    logic [IDX_W-1:0]  u_i, u_p, u_n, ps_i;
    logic [LID_W-1:0]  u_l, ps_l;
    logic [1:0]        ul, pl;
    logic              is_head, is_tail;

    // divider
    logic              div_start, div_done;
    logic [NUM_W-1:0]  div_num, div_quot;
    logic [LB_W-1:0]   div_den;

    // misc combinational
    logic [63:0]       key64;
    logic [LB_W-1:0]   hit_c, rd_c;
    logic [P_W-1:0]    cap_fx;
    logic [NUM_W-1:0]  one_fx, t1_fx, p_ext;
    logic [SUM_W-1:0]  p_sum;
    logic              from_t1;
    logic [LID_W-1:0]  dem_src, gh_id;
    logic              gh_ok;
    logic [31:0]       res_sat;
    logic              accept;

    assign key64   = 64'(i_s_tdata[31:0]);
    assign accept  = i_s_tvalid && o_s_tready;
    assign hit_c   = LB_W'(r_cur_size) + LB_W'(r_meta);
    assign rd_c    = LB_W'(rd_ks[SIZE_W-1:0]) + LB_W'(r_meta);
    assign cap_fx  = P_W'(r_cap) << FRAC_BITS;
    assign one_fx  = NUM_W'(1) << FRAC_BITS;
    assign t1_fx   = NUM_W'(r_lb[1-1]) << FRAC_BITS;
    assign p_ext   = NUM_W'(r_p);
    assign p_sum   = SUM_W'(r_p) + SUM_W'(r_delta);
    assign res_sat = r_res[LB_W-1] ? 32'hFFFF_FFFF : r_res[31:0];

    // demotion source: t1 when over target (or tied on a b2 hit) or when t2 is empty, else t2
    assign from_t1 = ((r_lb[0] != '0) &&
                      ((t1_fx > p_ext) || (r_in_b2 && (t1_fx == p_ext))))
                     || !r_ne[arc_rp_pkg::lix(arc_rp_pkg::ID_T2)];
    assign dem_src = from_t1 ? arc_rp_pkg::ID_T1 : arc_rp_pkg::ID_T2;

    // ghost victim: larger ghost list (b2 on a tie), falling back to the other one
    always_comb begin
        gh_id = (r_lb[2] > r_lb[3]) ? arc_rp_pkg::ID_B1 : arc_rp_pkg::ID_B2;
        if (!r_ne[arc_rp_pkg::lix(gh_id)]) begin
            gh_id = (gh_id == arc_rp_pkg::ID_B1) ? arc_rp_pkg::ID_B2 : arc_rp_pkg::ID_B1;
        end
        gh_ok = r_ne[arc_rp_pkg::lix(gh_id)];
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;

    arc_rp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_key      = r_key;
        n_size     = r_size;
        n_charge   = r_charge;
        n_cur_idx  = r_cur_idx;
        n_cur_list = r_cur_list;
        n_cur_prev = r_cur_prev;
        n_cur_next = r_cur_next;
        n_cur_size = r_cur_size;
        n_src      = r_src;
        n_dst      = r_dst;
        n_c        = r_c;
        n_push_ret = r_push_ret;
        n_in_b2    = r_in_b2;
        n_ghost    = r_ghost;
        n_reclaim  = r_reclaim;
        n_outcome  = r_outcome;
        n_dem      = r_dem;
        n_drop     = r_drop;
        n_delta    = r_delta;
        n_head     = r_head;
        n_tail     = r_tail;
        n_ne       = r_ne;
        n_lb       = r_lb;
        n_p        = r_p;
        n_res      = r_res;
        rd_addr    = r_idx;
        do_unl     = 1'b0;
        do_push    = 1'b0;
        u_i        = r_cur_idx;
        u_l        = r_cur_list;
        u_p        = r_cur_prev;
        u_n        = r_cur_next;
        ps_i       = r_cur_idx;
        ps_l       = r_dst;
        ks_we      = 1'b0;
        ks_addr    = r_idx;
        ks_d       = {r_key, r_size};
        ls_we      = 1'b0;
        ls_addr    = ps_i;
        ls_d       = ps_l;
        pv_we      = 1'b0;
        pv_addr    = '0;
        pv_d       = '0;
        nx_we      = 1'b0;
        nx_addr    = '0;
        nx_d       = '0;
        div_start  = 1'b0;
        div_num    = NUM_W'(r_lb[3]) << FRAC_BITS;
        div_den    = r_lb[2];
        ul         = '0;
        pl         = '0;
        is_head    = 1'b0;
        is_tail    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_key     = key64[KEY_BITS-1:0];
                    n_size    = i_s_tdata[55:32];
                    n_charge  = CHG_W'(i_s_tdata[55:32]) + CHG_W'(r_meta);
                    n_idx     = '0;
                    n_dem     = '0;
                    n_drop    = '0;
                    n_in_b2   = 1'b0;
                    n_ghost   = 1'b0;
                    n_reclaim = 1'b0;
                    n_state   = S_LRD;
                end
            end
            S_LRD: begin
                n_state = S_LCMP;
            end
            S_LCMP: begin
                n_cur_idx  = r_idx;
                n_cur_list = rd_list;
                n_cur_prev = rd_prev;
                n_cur_next = rd_next;
                n_cur_size = rd_ks[SIZE_W-1:0];
                if (r_valid[r_idx] && (rd_ks[KS_W-1:SIZE_W] == r_key)) begin
                    n_state = S_HIT;
                end else if (r_idx == IDX_W'(ENTRIES - 1)) begin
                    n_outcome = arc_rp_pkg::OC_MISS;
                    n_state   = S_INSCHK;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_LRD;
                end
            end
            S_HIT: begin
                do_unl = 1'b1;
                case (r_cur_list)
                    arc_rp_pkg::ID_T1: begin
                        n_lb[0]    = arc_rp_pkg::sub_sat(r_lb[0], hit_c);
                        n_c        = hit_c;
                        n_dst      = arc_rp_pkg::ID_T2;
                        n_outcome  = arc_rp_pkg::OC_T1_HIT;
                        n_push_ret = S_DONE;
                        n_state    = S_PUSH;
                    end
                    arc_rp_pkg::ID_T2: begin
                        n_c        = '0;
                        n_dst      = arc_rp_pkg::ID_T2;
                        n_outcome  = arc_rp_pkg::OC_T2_HIT;
                        n_push_ret = S_DONE;
                        n_state    = S_PUSH;
                    end
                    arc_rp_pkg::ID_B1: begin
                        div_num   = NUM_W'(r_lb[3]) << FRAC_BITS;
                        div_den   = r_lb[2];
                        n_lb[2]   = arc_rp_pkg::sub_sat(r_lb[2], hit_c);
                        n_ghost   = 1'b1;
                        n_outcome = arc_rp_pkg::OC_B1_GHOST;
                        if (r_lb[2] != '0 && r_lb[3] != '0) begin
                            div_start = 1'b1;
                            n_state   = S_DIV;
                        end else begin
                            n_delta = one_fx;
                            n_state = S_PADJ;
                        end
                    end
                    default: begin
                        div_num   = NUM_W'(r_lb[2]) << FRAC_BITS;
                        div_den   = r_lb[3];
                        n_lb[3]   = arc_rp_pkg::sub_sat(r_lb[3], hit_c);
                        n_ghost   = 1'b1;
                        n_in_b2   = 1'b1;
                        n_outcome = arc_rp_pkg::OC_B2_GHOST;
                        if (r_lb[2] != '0 && r_lb[3] != '0) begin
                            div_start = 1'b1;
                            n_state   = S_DIV;
                        end else begin
                            n_delta = one_fx;
                            n_state = S_PADJ;
                        end
                    end
                endcase
            end
            S_PUSH: begin
                do_push = 1'b1;
                n_lb[arc_rp_pkg::lix(r_dst)] = r_lb[arc_rp_pkg::lix(r_dst)] + r_c;
                n_state = r_push_ret;
            end
            S_DIV: begin
                if (div_done) begin
                    n_delta = div_quot;
                    n_state = S_PADJ;
                end
            end
            S_PADJ: begin
                if (r_in_b2) begin
                    n_p = (p_ext >= r_delta) ? P_W'(p_ext - r_delta) : '0;
                end else begin
                    n_p = (p_sum > SUM_W'(cap_fx)) ? cap_fx : P_W'(p_sum);
                end
                n_state = S_INSCHK;
            end
            S_INSCHK: begin
                if (33'(r_charge) > 33'(r_cap)) begin
                    n_outcome = arc_rp_pkg::OC_TOO_LARGE;
                    n_state   = S_DONE;
                end else begin
                    n_state = S_DEMCHK;
                end
            end
            S_DEMCHK: begin
                if ((34'(r_res) + 34'(r_charge)) > 34'(r_cap)) begin
                    if (r_ne[arc_rp_pkg::lix(dem_src)]) begin
                        rd_addr   = r_tail[arc_rp_pkg::lix(dem_src)];
                        n_cur_idx = r_tail[arc_rp_pkg::lix(dem_src)];
                        n_src     = dem_src;
                        n_state   = S_DEM;
                    end else begin
                        // byte totals are stale with no data left
                        n_lb[0] = '0;
                        n_lb[1] = '0;
                        n_res   = '0;
                    end
                end else begin
                    n_idx   = '0;
                    n_state = S_FREE;
                end
            end
            S_DEM: begin
                do_unl     = 1'b1;
                u_l        = r_src;
                u_p        = rd_prev;
                u_n        = rd_next;
                n_lb[arc_rp_pkg::lix(r_src)] =
                    arc_rp_pkg::sub_sat(r_lb[arc_rp_pkg::lix(r_src)], rd_c);
                n_res      = arc_rp_pkg::sub_sat(r_res, rd_c);
                n_dem      = r_dem + 1'b1;
                n_c        = rd_c;
                n_dst      = r_src + 3'd2;
                n_push_ret = S_PRUNE;
                n_state    = S_PUSH;
            end
            S_PRUNE: begin
                if ((34'(r_lb[2]) + 34'(r_lb[3])) > 34'(r_cap)) begin
                    if (gh_ok) begin
                        rd_addr   = r_tail[arc_rp_pkg::lix(gh_id)];
                        n_cur_idx = r_tail[arc_rp_pkg::lix(gh_id)];
                        n_src     = gh_id;
                        n_state   = S_DROP;
                    end else begin
                        n_lb[2] = '0;
                        n_lb[3] = '0;
                    end
                end else begin
                    n_state = S_DEMCHK;
                end
            end
            S_DROP: begin
                do_unl = 1'b1;
                u_l    = r_src;
                u_p    = rd_prev;
                u_n    = rd_next;
                n_lb[arc_rp_pkg::lix(r_src)] =
                    arc_rp_pkg::sub_sat(r_lb[arc_rp_pkg::lix(r_src)], rd_c);
                n_drop = r_drop + 1'b1;
                if (r_reclaim) begin
                    n_idx   = '0;
                    n_state = S_FREE;
                end else begin
                    n_state = S_PRUNE;
                end
            end
            S_FREE: begin
                if (!r_valid[r_idx]) begin
                    n_state = S_INS;
                end else if (r_idx == IDX_W'(ENTRIES - 1)) begin
                    if (gh_ok && !r_reclaim) begin
                        // table full: reclaim one ghost entry
                        rd_addr   = r_tail[arc_rp_pkg::lix(gh_id)];
                        n_cur_idx = r_tail[arc_rp_pkg::lix(gh_id)];
                        n_src     = gh_id;
                        n_reclaim = 1'b1;
                        n_state   = S_DROP;
                    end else begin
                        n_outcome = arc_rp_pkg::OC_FULL;
                        n_state   = S_DONE;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_INS: begin
                do_push = 1'b1;
                ps_i    = r_idx;
                ps_l    = r_ghost ? arc_rp_pkg::ID_T2 : arc_rp_pkg::ID_T1;
                ks_we   = 1'b1;
                ks_addr = r_idx;
                n_lb[arc_rp_pkg::lix(ps_l)] =
                    r_lb[arc_rp_pkg::lix(ps_l)] + LB_W'(r_charge);
                n_res   = r_res + LB_W'(r_charge);
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_vld) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // unlink: splice neighbors, fix head and tail
        if (do_unl) begin
            ul      = arc_rp_pkg::lix(u_l);
            is_head = (r_head[ul] == u_i);
            is_tail = (r_tail[ul] == u_i);
            if (is_head) begin
                if (is_tail) begin
                    n_ne[ul] = 1'b0;
                end else begin
                    n_head[ul] = u_n;
                end
            end else begin
                nx_we   = 1'b1;
                nx_addr = u_p;
                nx_d    = u_n;
            end
            if (is_tail) begin
                if (!is_head) begin
                    n_tail[ul] = u_p;
                end
            end else begin
                pv_we   = 1'b1;
                pv_addr = u_n;
                pv_d    = u_p;
            end
        end

        // push at head
        if (do_push) begin
            pl      = arc_rp_pkg::lix(ps_l);
            ls_we   = 1'b1;
            ls_addr = ps_i;
            ls_d    = ps_l;
            if (r_ne[pl]) begin
                pv_we   = 1'b1;
                pv_addr = r_head[pl];
                pv_d    = ps_i;
                nx_we   = 1'b1;
                nx_addr = ps_i;
                nx_d    = r_head[pl];
            end else begin
                n_tail[pl] = ps_i;
                n_ne[pl]   = 1'b1;
            end
            n_head[pl] = ps_i;
        end
    end

    // entry memories, registered reads
    always_ff @(posedge i_clk) begin
        if (ks_we) begin
            mem_ks[ks_addr] <= ks_d;
        end
        if (ls_we) begin
            mem_list[ls_addr] <= ls_d;
        end
        if (pv_we) begin
            mem_prev[pv_addr] <= pv_d;
        end
        if (nx_we) begin
            mem_next[nx_addr] <= nx_d;
        end
        rd_ks   <= mem_ks[rd_addr];
        rd_list <= mem_list[rd_addr];
        rd_prev <= mem_prev[rd_addr];
        rd_next <= mem_next[rd_addr];
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_ne      <= '0;
            r_lb      <= '{default: '0};
            r_p       <= '0;
            r_res     <= '0;
            r_cap     <= arc_rp_pkg::CAP_RESET;
            r_meta    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ne    <= n_ne;
            r_lb    <= n_lb;
            r_p     <= n_p;
            r_res   <= n_res;
            if (do_unl) begin
                r_valid[u_i] <= 1'b0;
            end
            if (do_push) begin
                r_valid[ps_i] <= 1'b1;
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    arc_rp_pkg::REG_CAPACITY: r_cap  <= i_cfg_wdata;
                    arc_rp_pkg::REG_METADATA: r_meta <= i_cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (r_state == S_DONE && !r_out_vld) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_key      <= n_key;
        r_size     <= n_size;
        r_charge   <= n_charge;
        r_cur_idx  <= n_cur_idx;
        r_cur_list <= n_cur_list;
        r_cur_prev <= n_cur_prev;
        r_cur_next <= n_cur_next;
        r_cur_size <= n_cur_size;
        r_src      <= n_src;
        r_dst      <= n_dst;
        r_c        <= n_c;
        r_push_ret <= n_push_ret;
        r_in_b2    <= n_in_b2;
        r_ghost    <= n_ghost;
        r_reclaim  <= n_reclaim;
        r_outcome  <= n_outcome;
        r_dem      <= n_dem;
        r_drop     <= n_drop;
        r_delta    <= n_delta;
        r_head     <= n_head;
        r_tail     <= n_tail;
        if (r_state == S_DONE && !r_out_vld) begin
            r_out_data <= {3'b000, res_sat, r_drop, r_dem, r_outcome};
        end
    end

    // allocated slot must be free
    a_ins_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS) |-> !r_valid[r_idx])
        else $error("insert into occupied entry");

    // demotion only from a list that holds entries
    a_dem_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEM) |-> r_ne[arc_rp_pkg::lix(r_src)])
        else $error("demotion from empty list");

    // divider finishes only while the sequencer waits for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("stray divider completion");

    // a rejected oversize request never demotes or drops
    a_too_large: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out_data[2:0] == arc_rp_pkg::OC_TOO_LARGE))
        |-> (r_out_data[20:3] == '0))
        else $error("oversize request changed lists");

endmodule
